/* sv/pva_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the polyphonic voice allocator
// no dependencies; used by pva_cell and polyphonic_voice_allocator
package pva_pkg;

	localparam int NOTE_W = 7;
	localparam int CH_W   = 4;
	localparam int AGE_W  = 32;
	localparam int IDX_W  = 4;
	localparam int CNT_W  = IDX_W + 1;
	localparam int CFG_W  = 4;

	localparam logic KIND_OFF = 1'b0;
	localparam logic KIND_ON  = 1'b1;

	localparam logic [CFG_W-1:0] VOICE_COUNT_RESET = CFG_W'(3);
	localparam logic [AGE_W-1:0] AGE_RESET         = AGE_W'(1);

	// search record that walks down the row of voice cells
	typedef struct packed {
		logic              valid;
		logic              kind;
		logic [CH_W-1:0]   channel;
		logic [NOTE_W-1:0] note;
		logic              free_hit;
		logic [IDX_W-1:0]  free_idx;
		logic              ch_hit;
		logic [IDX_W-1:0]  ch_idx;
		logic              match_hit;
		logic [IDX_W-1:0]  match_idx;
		logic [AGE_W-1:0]  best_age;
		logic [IDX_W-1:0]  best_idx;
	} scan_t;

	// update broadcast to all cells
	typedef struct packed {
		logic              en;
		logic              kind;
		logic [IDX_W-1:0]  idx;
		logic [NOTE_W-1:0] note;
		logic [CH_W-1:0]   channel;
		logic [AGE_W-1:0]  age;
	} wr_t;

endpackage

/* sv/pva_cell.sv */
`timescale 1ns / 1ps
// one voice slot: holds active flag, note, channel and age of a voice
// folds its voice into the search record and passes it on; uses pva_pkg
module pva_cell #(
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [pva_pkg::CNT_W-1:0] voices,
	input  pva_pkg::scan_t            scan_in,
	output pva_pkg::scan_t            scan_out,
	input  pva_pkg::wr_t              wr
);

	localparam logic [pva_pkg::CNT_W-1:0] MY_CNT = pva_pkg::CNT_W'(IDX);
	localparam logic [pva_pkg::IDX_W-1:0] MY_IDX = pva_pkg::IDX_W'(IDX);

	logic                       active_q;
	logic [pva_pkg::NOTE_W-1:0] note_q;
	logic [pva_pkg::CH_W-1:0]   channel_q;
	logic [pva_pkg::AGE_W-1:0]  age_q;
	pva_pkg::scan_t             nxt;
	pva_pkg::scan_t             scan_q;
	logic                       in_use;

	assign in_use = MY_CNT < voices;

	always_comb begin
		nxt = scan_in;
		if (in_use) begin
			if (!active_q && !scan_in.free_hit) begin
				nxt.free_hit = 1'b1;
				nxt.free_idx = MY_IDX;
			end
			if (channel_q == scan_in.channel && !scan_in.ch_hit) begin
				nxt.ch_hit = 1'b1;
				nxt.ch_idx = MY_IDX;
			end
			if (active_q && note_q == scan_in.note && !scan_in.match_hit) begin
				nxt.match_hit = 1'b1;
				nxt.match_idx = MY_IDX;
			end
			// first cell seeds the oldest-voice search, strict less keeps lowest index
			if (IDX == 0 || age_q < scan_in.best_age) begin
				nxt.best_age = age_q;
				nxt.best_idx = MY_IDX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q <= nxt;
		end
	end

	assign scan_out = scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			note_q    <= '0;
			channel_q <= '0;
			age_q     <= '0;
		end else if (wr.en && wr.idx == MY_IDX) begin
			if (wr.kind == pva_pkg::KIND_ON) begin
				active_q  <= 1'b1;
				note_q    <= wr.note;
				channel_q <= wr.channel;
				age_q     <= wr.age;
			end else begin
				active_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/polyphonic_voice_allocator.sv */
`timescale 1ns / 1ps
// polyphonic voice allocator top level: row of voice cells plus decision and output stage
// depends on pva_pkg and pva_cell
//
// s_* channel takes note events: tuser[0] is the kind (0 note off, 1 note on),
// tdata holds channel and note. m_* channel gives at most one beat per event:
// tuser[0] is the command (0 released, 1 started), tdata voice index and note.
// cfg_* writes voice_count (voices in use, saturated to 1..MAX_VOICES); it is
// always ready; the user must write it only while no event is in flight, as the
// block itself does not enforce this. An event walks the row of MAX_VOICES cells
// one cell per cycle, collecting the lowest free voice, lowest same-channel voice,
// oldest voice and lowest active voice with the note. The finished record is
// registered after the walk, and the decision is written back to the chosen cell
// in the same cycle the result is registered. One event is in flight at a time,
// so a new event is taken only once the last one's decision has been applied.
// The input is taken again while a result still waits on the output; a stalled
// output holds the decision of the following event until the beat leaves.
// Reset clears all voices, sets the age counter to one and voice_count to 3.
module polyphonic_voice_allocator #(
	parameter int MAX_VOICES = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [15:0]               s_tdata,   // channel[3:0], note[10:4]
	input  logic [0:0]                s_tuser,   // kind[0]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [15:0]               m_tdata,   // voice_index[3:0], note_out[10:4]
	output logic [0:0]                m_tuser,   // command[0]
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [pva_pkg::CFG_W-1:0] cfg_data
);

	localparam logic [pva_pkg::CNT_W-1:0] MAX_CNT = pva_pkg::CNT_W'(MAX_VOICES);

	logic [pva_pkg::CFG_W-1:0]  voice_count_q;
	logic [pva_pkg::CNT_W-1:0]  voices;
	logic [pva_pkg::AGE_W-1:0]  age_q;
	logic                       busy_q;
	pva_pkg::scan_t             chain [MAX_VOICES+1];
	pva_pkg::scan_t             fin_q;
	pva_pkg::wr_t               wr;
	logic                       accept;
	logic                       has_result;
	logic                       out_free;
	logic                       apply;
	logic [pva_pkg::IDX_W-1:0]  pick;
	logic [pva_pkg::IDX_W-1:0]  voice_index_q;
	logic [pva_pkg::NOTE_W-1:0] note_out_q;
	logic                       command_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy_q;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_count_q <= pva_pkg::VOICE_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			voice_count_q <= cfg_data;
		end
	end

	always_comb begin
		voices = pva_pkg::CNT_W'(voice_count_q);
		if (voices == '0) begin
			voices = pva_pkg::CNT_W'(1);
		end else if (voices > MAX_CNT) begin
			voices = MAX_CNT;
		end
	end

	always_comb begin
		chain[0]           = '0;
		chain[0].valid     = accept;
		chain[0].kind      = s_tuser[0];
		chain[0].channel   = s_tdata[3:0];
		chain[0].note      = s_tdata[10:4];
	end

	for (genvar g = 0; g < MAX_VOICES; g++) begin : g_cell
		pva_cell #(.IDX(g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.voices   (voices),
			.scan_in  (chain[g]),
			.scan_out (chain[g+1]),
			.wr       (wr)
		);
	end

	// holds the finished record until the output slot can take its result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= '0;
		end else if (chain[MAX_VOICES].valid) begin
			fin_q <= chain[MAX_VOICES];
		end else if (apply) begin
			fin_q.valid <= 1'b0;
		end
	end

	always_comb begin
		priority if (fin_q.kind == pva_pkg::KIND_OFF) begin
			pick = fin_q.match_idx;
		end else if (fin_q.free_hit) begin
			pick = fin_q.free_idx;
		end else if (fin_q.ch_hit) begin
			pick = fin_q.ch_idx;
		end else begin
			pick = fin_q.best_idx;
		end
	end

	assign has_result = (fin_q.kind == pva_pkg::KIND_ON) || fin_q.match_hit;
	assign out_free   = !m_tvalid || m_tready;
	assign apply      = fin_q.valid && (!has_result || out_free);

	always_comb begin
		wr.en      = apply && has_result;
		wr.kind    = fin_q.kind;
		wr.idx     = pick;
		wr.note    = fin_q.note;
		wr.channel = fin_q.channel;
		wr.age     = age_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q  <= pva_pkg::AGE_RESET;
			busy_q <= 1'b0;
		end else begin
			if (apply && fin_q.kind == pva_pkg::KIND_ON) begin
				age_q <= age_q + pva_pkg::AGE_W'(1);
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (apply) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (apply && has_result) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply && has_result) begin
			command_q     <= fin_q.kind;
			voice_index_q <= pick;
			note_out_q    <= fin_q.note;
		end
	end

	assign m_tuser = command_q;
	assign m_tdata = {5'b0, note_out_q, voice_index_q};

	// a finished record only exists while the event is still in flight
	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q.valid |-> busy_q)
		else $error("finished record without event in flight");

	// a write-back with a result always shows up on the output next cycle
	a_apply_out: assert property (@(posedge clk) disable iff (!arst_n)
		(apply && has_result) |=> m_tvalid)
		else $error("decision made but no output beat");

	// the reported voice is always one of the voices in use
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (pva_pkg::CNT_W'(wr.idx) < voices))
		else $error("voice index outside the voices in use");

	// one event at a time through the row
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input taken while an event is in flight");

endmodule

/* tb/polyphonic_voice_allocator_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for polyphonic_voice_allocator: directed table then random note traffic
// depends on pva_pkg and polyphonic_voice_allocator; holds its own voice table predictor
module polyphonic_voice_allocator_tb;

	localparam int VOICES      = 12;
	localparam int DRAIN       = VOICES + 8;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_ITEMS = 140;
	localparam int SCRIPT_LEN  = 25;

	localparam logic CMD_RELEASE = 1'b0;
	localparam logic CMD_START   = 1'b1;

	typedef enum logic {ROW_EVENT, ROW_SET_COUNT} row_op_e;
	typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_BEAT} exp_mode_e;

	typedef struct packed {
		logic                       cmd;
		logic [pva_pkg::IDX_W-1:0]  idx;
		logic [pva_pkg::NOTE_W-1:0] note;
	} beat_t;

	typedef struct {
		row_op_e                    op;
		logic                       kind;
		logic [pva_pkg::CH_W-1:0]   channel;
		logic [pva_pkg::NOTE_W-1:0] note;
		logic [pva_pkg::CFG_W-1:0]  count;
		exp_mode_e                  mode;
		logic                       cmd;
		logic [pva_pkg::IDX_W-1:0]  idx;
		logic [pva_pkg::NOTE_W-1:0] out_note;
	} row_t;

	// reset count is three voices
	row_t script [SCRIPT_LEN] = '{
		'{ROW_EVENT, pva_pkg::KIND_OFF, 0, 0, 0, EXP_NONE, 0, 0, 0},
		'{ROW_EVENT, pva_pkg::KIND_ON, 0, 0, 0, EXP_BEAT, CMD_START, 0, 0},
		'{ROW_EVENT, pva_pkg::KIND_ON, 15, 127, 0, EXP_BEAT, CMD_START, 1, 127},
		'{ROW_EVENT, pva_pkg::KIND_ON, 5, 60, 0, EXP_BEAT, CMD_START, 2, 60},
		// table full, same channel as voice 1
		'{ROW_EVENT, pva_pkg::KIND_ON, 15, 10, 0, EXP_BEAT, CMD_START, 1, 10},
		// table full, no channel match: oldest is voice 0
		'{ROW_EVENT, pva_pkg::KIND_ON, 7, 20, 0, EXP_BEAT, CMD_START, 0, 20},
		'{ROW_EVENT, pva_pkg::KIND_OFF, 3, 127, 0, EXP_NONE, 0, 0, 0},
		// release ignores the channel
		'{ROW_EVENT, pva_pkg::KIND_OFF, 9, 60, 0, EXP_BEAT, CMD_RELEASE, 2, 60},
		'{ROW_EVENT, pva_pkg::KIND_ON, 2, 60, 0, EXP_BEAT, CMD_START, 2, 60},
		'{ROW_EVENT, pva_pkg::KIND_ON, 2, 61, 0, EXP_BEAT, CMD_START, 2, 61},
		'{ROW_EVENT, pva_pkg::KIND_OFF, 0, 20, 0, EXP_BEAT, CMD_RELEASE, 0, 20},
		'{ROW_EVENT, pva_pkg::KIND_OFF, 0, 20, 0, EXP_NONE, 0, 0, 0},
		// zero count means a single voice
		'{ROW_SET_COUNT, pva_pkg::KIND_OFF, 0, 0, 0, EXP_NONE, 0, 0, 0},
		'{ROW_EVENT, pva_pkg::KIND_ON, 4, 33, 0, EXP_BEAT, CMD_START, 0, 33},
		'{ROW_EVENT, pva_pkg::KIND_ON, 8, 34, 0, EXP_BEAT, CMD_START, 0, 34},
		// voice 2 still holds 61 but is out of range
		'{ROW_EVENT, pva_pkg::KIND_OFF, 0, 61, 0, EXP_NONE, 0, 0, 0},
		'{ROW_SET_COUNT, pva_pkg::KIND_OFF, 0, 0, 15, EXP_NONE, 0, 0, 0},
		'{ROW_EVENT, pva_pkg::KIND_ON, 1, 1, 0, EXP_PREDICT, 0, 0, 0},
		'{ROW_EVENT, pva_pkg::KIND_OFF, 6, 61, 0, EXP_BEAT, CMD_RELEASE, 2, 61},
		'{ROW_EVENT, pva_pkg::KIND_ON, 15, 127, 0, EXP_PREDICT, 0, 0, 0},
		'{ROW_EVENT, pva_pkg::KIND_OFF, 0, 1, 0, EXP_PREDICT, 0, 0, 0},
		'{ROW_SET_COUNT, pva_pkg::KIND_OFF, 0, 0, 12, EXP_NONE, 0, 0, 0},
		'{ROW_EVENT, pva_pkg::KIND_ON, 0, 0, 0, EXP_PREDICT, 0, 0, 0},
		'{ROW_EVENT, pva_pkg::KIND_OFF, 15, 127, 0, EXP_PREDICT, 0, 0, 0},
		'{ROW_EVENT, pva_pkg::KIND_ON, 15, 127, 0, EXP_PREDICT, 0, 0, 0}
	};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [15:0]                s_tdata;    // channel[3:0], note[10:4]
	logic [0:0]                 s_tuser;    // kind[0]
	logic                       m_tvalid;
	logic                       m_tready;
	logic [15:0]                m_tdata;    // voice_index[3:0], note_out[10:4]
	logic [0:0]                 m_tuser;    // command[0]
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [pva_pkg::CFG_W-1:0]  cfg_data;

	// tag that travels with the beat on s_* so the monitor knows typed rows
	exp_mode_e                  tag_mode;
	beat_t                      tag_beat;

	// predictor state
	logic [pva_pkg::CFG_W-1:0]  count_reg;
	logic                       held [VOICES];
	logic [pva_pkg::NOTE_W-1:0] held_note [VOICES];
	logic [pva_pkg::CH_W-1:0]   held_channel [VOICES];
	logic [pva_pkg::AGE_W-1:0]  held_age [VOICES];
	logic [pva_pkg::AGE_W-1:0]  age_stamp;

	beat_t pending_beats [$];

	bit idle_on;
	int stall_left;
	int quiet_cycles;
	int failures;
	int events_sent, starts_seen, releases_seen, steals, settings;

	polyphonic_voice_allocator #(.MAX_VOICES(VOICES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_voices();
		count_reg = pva_pkg::VOICE_COUNT_RESET;
		for (int i = 0; i < VOICES; i++) begin
			held[i] = 1'b0;
			held_note[i] = '0;
			held_channel[i] = '0;
			held_age[i] = '0;
		end
		age_stamp = pva_pkg::AGE_RESET;
	endfunction

	// applies one note event to the voice table, returns the beat it causes if any
	function automatic void predict_event(input logic kind,
			input logic [pva_pkg::CH_W-1:0] ch, input logic [pva_pkg::NOTE_W-1:0] nt,
			output bit got, output beat_t b);
		int n;
		int v;
		n = (count_reg == 0) ? 1 : (count_reg > VOICES) ? VOICES : int'(count_reg);
		got = 0;
		b = '0;
		v = -1;
		if (kind == pva_pkg::KIND_ON) begin
			for (int i = 0; i < n; i++)
				if (v < 0 && !held[i]) v = i;
			if (v < 0) begin
				steals++;
				for (int i = 0; i < n; i++)
					if (v < 0 && held_channel[i] == ch) v = i;
			end
			if (v < 0) begin
				v = 0;
				for (int i = 1; i < n; i++)
					if (held_age[i] < held_age[v]) v = i;
			end
			held[v] = 1'b1;
			held_note[v] = nt;
			held_channel[v] = ch;
			held_age[v] = age_stamp;
			age_stamp = age_stamp + pva_pkg::AGE_W'(1);
			got = 1;
			b = '{CMD_START, pva_pkg::IDX_W'(v), nt};
		end else begin
			for (int i = 0; i < n; i++)
				if (v < 0 && held[i] && held_note[i] == nt) v = i;
			if (v >= 0) begin
				held[v] = 1'b0;
				got = 1;
				b = '{CMD_RELEASE, pva_pkg::IDX_W'(v), nt};
			end
		end
	endfunction

	function automatic void compare_field(string what, int want, int seen);
		if (want != seen) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
			failures++;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// sink side backpressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
				: $urandom_range(11, 39);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		bit got;
		beat_t b;
		beat_t seen;
		bit moved;
		moved = 0;
		if (cfg_valid && cfg_ready) begin
			count_reg = cfg_data;
			settings++;
			moved = 1;
		end
		if (s_tvalid && s_tready) begin
			predict_event(s_tuser[0], s_tdata[3:0], s_tdata[10:4], got, b);
			if (tag_mode == EXP_NONE) got = 0;
			if (tag_mode == EXP_BEAT) begin
				got = 1;
				b = tag_beat;
			end
			if (got) pending_beats.push_back(b);
			events_sent++;
			moved = 1;
		end
		if (m_tvalid && m_tready) begin
			seen = '{m_tuser[0], m_tdata[3:0], m_tdata[10:4]};
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat cmd=%0d idx=%0d note=%0d", $time,
					seen.cmd, seen.idx, seen.note);
				failures++;
			end else begin
				b = pending_beats.pop_front();
				compare_field("command", b.cmd, seen.cmd);
				compare_field("voice_index", b.idx, seen.idx);
				compare_field("note_out", b.note, seen.note);
			end
			if (seen.cmd == CMD_START) starts_seen++;
			else releases_seen++;
			moved = 1;
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("%0t: no progress for %0d cycles, %0d beats outstanding", $time,
			QUIET_LIMIT, pending_beats.size());
		$display("tb: failure");
		$finish;
	end

	task automatic send_event(input logic kind, input logic [pva_pkg::CH_W-1:0] ch,
			input logic [pva_pkg::NOTE_W-1:0] nt, input exp_mode_e mode, input beat_t b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, nt, ch};
		s_tuser  <= kind;
		tag_mode <= mode;
		tag_beat <= b;
		do @(posedge clk); while (!s_tready);
	endtask

	// waits for the block to go quiet, then writes voice_count
	task automatic set_voice_count(input logic [pva_pkg::CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		// let the monitor book the last accepted beat first
		@(posedge clk);
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int counts [12] = '{12, 1, 15, 0, 6, 3, 12, 2, 9, 4, 11, 7};
		logic kind;
		logic [pva_pkg::CH_W-1:0] ch;
		logic [pva_pkg::NOTE_W-1:0] nt;
		int p_on;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		m_tready  <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		tag_mode  <= EXP_PREDICT;
		tag_beat  <= '0;
		clear_voices();
		idle_on = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[r]) begin
			if (script[r].op == ROW_SET_COUNT)
				set_voice_count(script[r].count);
			else
				send_event(script[r].kind, script[r].channel, script[r].note, script[r].mode,
					'{script[r].cmd, script[r].idx, script[r].out_note});
		end

		foreach (counts[p]) begin
			set_voice_count(pva_pkg::CFG_W'(counts[p]));
			idle_on = (p % 3 != 2);
			p_on = $urandom_range(45, 80);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				kind = ($urandom_range(0, 99) < p_on) ? pva_pkg::KIND_ON : pva_pkg::KIND_OFF;
				ch = $urandom_range(0, 1) ? pva_pkg::CH_W'($urandom_range(0, 3))
					: pva_pkg::CH_W'($urandom_range(0, 15));
				if (kind == pva_pkg::KIND_ON)
					nt = ($urandom_range(0, 3) == 0) ? pva_pkg::NOTE_W'($urandom_range(0, 127))
						: pva_pkg::NOTE_W'($urandom_range(36, 84));
				else if ($urandom_range(0, 9) < 7)
					nt = held_note[$urandom_range(0, VOICES - 1)];
				else
					nt = pva_pkg::NOTE_W'($urandom_range(0, 127));
				send_event(kind, ch, nt, EXP_PREDICT, '0);
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (pending_beats.size() != 0) failures++;
		$display("summary: %0d note events, %0d voice starts and %0d releases checked",
			events_sent, starts_seen, releases_seen);
		$display("summary: %0d allocations on a full table, %0d voice_count writes",
			steals, settings);
		if (failures == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches", failures);
			$display("tb: failure");
		end
		$finish;
	end

endmodule
